### hw/rtl/erx_pkg.sv
// Package for the escaped reference expander: payload structs, character codes,
// error codes and the command/status structs between controller and datapath.
// No dependencies.
package erx_pkg;

   localparam int ERR_OFF_W = 32;

   localparam logic [7:0] CHAR_GT   = 8'h3E;  // '>'
   localparam logic [7:0] CHAR_LT   = 8'h3C;  // '<'
   localparam logic [7:0] CHAR_AT   = 8'h40;  // '@'
   localparam logic [7:0] CHAR_ZERO = 8'h30;  // '0'

   localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
   localparam logic [3:0] BCD_ADJ_ADD = 4'd3;

   typedef enum logic [1:0] {
      ERR_NONE = 2'd0,
      ERR_PEEK = 2'd1,
      ERR_REF  = 2'd2
   } err_code_type;

   typedef enum logic [1:0] {
      SRC_BYTE,
      SRC_DIGIT,
      SRC_ERROR
   } out_src_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_field;
   } req_type;

   typedef struct packed {
      logic [7:0]           out_byte;
      logic                 is_error;
      err_code_type         error_code;
      logic [ERR_OFF_W-1:0] error_offset;
      logic                 last_of_field;
   } rsp_type;

   typedef struct packed {
      logic         accept;
      logic         mark;
      logic         id_store;
      logic         id_done;
      err_code_type err_code;
      logic         conv_step;
      logic         digit_shift;
      logic         load;
      out_src_type  src;
      logic         last;
   } erx_cmd_type;

   typedef struct packed {
      logic id_full;
      logic conv_last;
      logic top_zero;
      logic one_left;
   } erx_sts_type;

endpackage

### hw/rtl/erx_datapath.sv
// Datapath of the escaped reference expander: offsets, id accumulator,
// shift-add-3 binary to BCD converter and the result register.
// Depends on erx_pkg.
module erx_datapath import erx_pkg::*; #(
   parameter int ID_BYTES    = 8,
   parameter int OFFSET_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  req_type     req_payload,
   input  erx_cmd_type cmd,
   output erx_sts_type sts,
   output rsp_type     rsp_payload
);

   localparam int ACC_W  = 8 * ID_BYTES;
   // Decimal digits of the largest id: floor(bits * log10(2)) + 1.
   localparam int DIGITS = (ACC_W * 30103) / 100000 + 1;
   localparam int BCD_W  = 4 * DIGITS;
   localparam int CNT_W  = (ID_BYTES > 1) ? $clog2(ID_BYTES) : 1;
   localparam int ITER_W = $clog2(ACC_W);
   localparam int DCNT_W = $clog2(DIGITS + 1);

   logic [ACC_W-1:0]       acc_ff, acc_in;
   logic [CNT_W-1:0]       id_cnt_ff, id_cnt_in;
   logic [BCD_W-1:0]       bcd_ff, bcd_in;
   logic [ITER_W-1:0]      iter_ff, iter_in;
   logic [DCNT_W-1:0]      dcnt_ff, dcnt_in;
   logic [OFFSET_BITS-1:0] fo_ff, fo_in;
   logic [OFFSET_BITS-1:0] mark_ff, mark_in;
   err_code_type           err_code_ff, err_code_in;
   logic [OFFSET_BITS-1:0] err_off_ff, err_off_in;
   logic [7:0]             byte_ff, byte_in;
   rsp_type                rsp_ff, rsp_in;
   logic [BCD_W-1:0]       bcd_adj;
   logic [3:0]             nib;

   always_comb begin
      acc_in      = acc_ff;
      id_cnt_in   = id_cnt_ff;
      bcd_in      = bcd_ff;
      iter_in     = iter_ff;
      dcnt_in     = dcnt_ff;
      fo_in       = fo_ff;
      mark_in     = mark_ff;
      err_code_in = err_code_ff;
      err_off_in  = err_off_ff;
      byte_in     = byte_ff;
      rsp_in      = rsp_ff;
      bcd_adj     = bcd_ff;
      nib         = '0;

      if (cmd.accept) begin
         byte_in     = req_payload.in_byte;
         err_code_in = cmd.err_code;
         if (cmd.err_code == ERR_PEEK) begin
            err_off_in = fo_ff + OFFSET_BITS'(1);
         end else if (cmd.mark) begin
            err_off_in = fo_ff;
         end else begin
            err_off_in = mark_ff;
         end
         if (cmd.mark) begin
            acc_in    = '0;
            id_cnt_in = '0;
            mark_in   = fo_ff;
         end
         if (cmd.id_store) begin
            for (int i = 0; i < ID_BYTES; i++) begin
               if (id_cnt_ff == CNT_W'(i)) begin
                  acc_in[8*i +: 8] = req_payload.in_byte;
               end
            end
            id_cnt_in = cmd.id_done ? '0 : id_cnt_ff + CNT_W'(1);
         end
         if (cmd.id_done) begin
            bcd_in  = '0;
            iter_in = '0;
            dcnt_in = DCNT_W'(DIGITS);
         end
         if (req_payload.end_of_field) begin
            fo_in   = '0;
            mark_in = '0;
         end else begin
            fo_in = fo_ff + OFFSET_BITS'(1);
         end
      end

      // One shift-add-3 step: the id bits move MSB first into the BCD digits.
      if (cmd.conv_step) begin
         for (int d = 0; d < DIGITS; d++) begin
            nib = bcd_ff[4*d +: 4];
            bcd_adj[4*d +: 4] = (nib >= BCD_ADJ_MIN) ? nib + BCD_ADJ_ADD : nib;
         end
         bcd_in  = {bcd_adj[BCD_W-2:0], acc_ff[ACC_W-1]};
         acc_in  = {acc_ff[ACC_W-2:0], 1'b0};
         iter_in = iter_ff + ITER_W'(1);
      end

      if (cmd.load) begin
         rsp_in.last_of_field = cmd.last;
         case (cmd.src)
            SRC_BYTE: begin
               rsp_in.out_byte     = byte_ff;
               rsp_in.is_error     = 1'b0;
               rsp_in.error_code   = ERR_NONE;
               rsp_in.error_offset = '0;
            end
            SRC_DIGIT: begin
               rsp_in.out_byte     = CHAR_ZERO + {4'h0, bcd_ff[BCD_W-1 -: 4]};
               rsp_in.is_error     = 1'b0;
               rsp_in.error_code   = ERR_NONE;
               rsp_in.error_offset = '0;
            end
            default: begin
               rsp_in.out_byte     = '0;
               rsp_in.is_error     = 1'b1;
               rsp_in.error_code   = err_code_ff;
               rsp_in.error_offset = ERR_OFF_W'(err_off_ff);
            end
         endcase
      end

      if (cmd.digit_shift) begin
         bcd_in  = {bcd_ff[BCD_W-5:0], 4'h0};
         dcnt_in = dcnt_ff - DCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         id_cnt_ff <= '0;
         fo_ff     <= '0;
         mark_ff   <= '0;
      end else begin
         id_cnt_ff <= id_cnt_in;
         fo_ff     <= fo_in;
         mark_ff   <= mark_in;
      end
      acc_ff      <= acc_in;
      bcd_ff      <= bcd_in;
      iter_ff     <= iter_in;
      dcnt_ff     <= dcnt_in;
      err_code_ff <= err_code_in;
      err_off_ff  <= err_off_in;
      byte_ff     <= byte_in;
      rsp_ff      <= rsp_in;
   end

   assign sts.id_full   = (id_cnt_ff == CNT_W'(ID_BYTES - 1));
   assign sts.conv_last = (iter_ff == ITER_W'(ACC_W - 1));
   assign sts.top_zero  = (bcd_ff[BCD_W-1 -: 4] == 4'h0);
   assign sts.one_left  = (dcnt_ff == DCNT_W'(1));
   assign rsp_payload   = rsp_ff;

endmodule

### hw/rtl/erx_ctrl.sv
// Controller of the escaped reference expander: scan mode, per-transaction plan
// and the sequencer that emits copies, id digits and error items.
// Depends on erx_pkg.
module erx_ctrl import erx_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_payload,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  erx_sts_type sts,
   output erx_cmd_type cmd
);

   typedef enum logic [1:0] {
      MODE_NORMAL,
      MODE_PEEK1,
      MODE_PEEK2,
      MODE_ID
   } mode_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_COPY,
      S_CONV,
      S_SKIP,
      S_DIGIT,
      S_ERR
   } state_type;

   state_type    state_ff, state_in;
   mode_type     mode_ff, mode_in;
   logic         dup_ff, dup_in;
   err_code_type err_ff, err_in;
   logic         last_ff, last_in;
   logic         rsp_valid_ff, rsp_valid_in;

   mode_type     plain_mode;
   logic         copies2;
   logic         copies1;
   logic         can_load;
   logic [7:0]   b;

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      dup_in       = dup_ff;
      err_in       = err_ff;
      last_in      = last_ff;
      cmd          = '0;
      cmd.src      = SRC_BYTE;
      cmd.err_code = ERR_NONE;
      b            = req_payload.in_byte;
      plain_mode   = (b == CHAR_GT) ? MODE_PEEK1 : MODE_NORMAL;
      copies1      = 1'b0;
      copies2      = 1'b0;
      can_load     = !rsp_valid_ff || rsp_ready;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               unique case (mode_ff)
                  MODE_NORMAL: begin
                     copies1 = 1'b1;
                     mode_in = plain_mode;
                  end
                  MODE_PEEK1: begin
                     if (b == CHAR_LT) begin
                        copies1 = 1'b1;
                        mode_in = MODE_PEEK2;
                     end else begin
                        copies2 = 1'b1;
                        mode_in = plain_mode;
                     end
                  end
                  MODE_PEEK2: begin
                     if (b == CHAR_AT) begin
                        copies1  = 1'b1;
                        cmd.mark = 1'b1;
                        mode_in  = MODE_ID;
                     end else begin
                        copies2 = 1'b1;
                        mode_in = plain_mode;
                     end
                  end
                  MODE_ID: begin
                     cmd.id_store = 1'b1;
                     if (sts.id_full) begin
                        cmd.id_done = 1'b1;
                        mode_in     = MODE_NORMAL;
                     end
                  end
               endcase
               // A field that ends with a peek or a reference still open reports it.
               if (req_payload.end_of_field) begin
                  if (mode_in == MODE_PEEK1 || mode_in == MODE_PEEK2) begin
                     cmd.err_code = ERR_PEEK;
                  end else if (mode_in == MODE_ID) begin
                     cmd.err_code = ERR_REF;
                  end
                  mode_in = MODE_NORMAL;
               end
               err_in  = cmd.err_code;
               last_in = req_payload.end_of_field;
               dup_in  = copies2;
               priority if (copies1 || copies2) begin
                  state_in = S_COPY;
               end else if (cmd.id_done) begin
                  state_in = S_CONV;
               end else if (cmd.err_code != ERR_NONE) begin
                  state_in = S_ERR;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_COPY: begin
            if (can_load) begin
               cmd.load = 1'b1;
               cmd.src  = SRC_BYTE;
               cmd.last = last_ff && !dup_ff && (err_ff == ERR_NONE);
               if (dup_ff) begin
                  dup_in = 1'b0;
               end else if (err_ff != ERR_NONE) begin
                  state_in = S_ERR;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_CONV: begin
            cmd.conv_step = 1'b1;
            if (sts.conv_last) begin
               state_in = S_SKIP;
            end
         end
         S_SKIP: begin
            // Leading zeros are dropped; the last digit always stays.
            if (sts.top_zero && !sts.one_left) begin
               cmd.digit_shift = 1'b1;
            end else begin
               state_in = S_DIGIT;
            end
         end
         S_DIGIT: begin
            if (can_load) begin
               cmd.load        = 1'b1;
               cmd.src         = SRC_DIGIT;
               cmd.digit_shift = 1'b1;
               cmd.last        = last_ff && sts.one_left;
               if (sts.one_left) begin
                  state_in = S_IDLE;
               end
            end
         end
         S_ERR: begin
            if (can_load) begin
               cmd.load = 1'b1;
               cmd.src  = SRC_ERROR;
               cmd.last = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (cmd.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= MODE_NORMAL;
         dup_ff       <= 1'b0;
         err_ff       <= ERR_NONE;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         dup_ff       <= dup_in;
         err_ff       <= err_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

### hw/rtl/escaped_reference_expander.sv
// Escaped reference expander: bytes of a field are copied to the output; a byte
// after '>' (or after '><') is echoed as a peek copy and then copied again unless
// it continues the marker, and after '><@' the next ID_BYTES little-endian bytes
// are replaced by their decimal text. One transaction is taken at a time: an
// ordinary byte is accepted and then copied (twice when it is echoed, with an
// error item after it if the field ends inside a peek or a reference); an id
// byte that does not complete the id is only stored (an error item follows when
// the field ends on it); and the final id byte is accepted, run through the
// bit-serial shift-add-3 converter, stripped of leading zeros and emitted as one
// item per decimal digit, up to 20 digits for 8-byte ids. Output back-pressure
// stalls the copies, digits and error items. The result register lets a new
// transaction be accepted while the last result still waits.
// Depends on erx_pkg, erx_ctrl and erx_datapath.
module escaped_reference_expander import erx_pkg::*; #(
   parameter int ID_BYTES    = 8,
   parameter int OFFSET_BITS = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   erx_cmd_type cmd;
   erx_sts_type sts;

   erx_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .sts         (sts),
      .cmd         (cmd)
   );

   erx_datapath #(
      .ID_BYTES    (ID_BYTES),
      .OFFSET_BITS (OFFSET_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_payload (rsp_payload)
   );

`ifndef ASSERT_OFF
   // The result register is never overwritten while it holds an untaken result.
   a_load_safe: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (!rsp_valid || rsp_ready))
      else $error("result register overwritten");

   // An error item always closes its field.
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.is_error) |-> rsp_payload.last_of_field)
      else $error("error item without last_of_field");

   // Error items carry a real code and no data byte.
   a_err_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.is_error) |->
         ((rsp_payload.error_code == ERR_PEEK || rsp_payload.error_code == ERR_REF)
          && rsp_payload.out_byte == 8'h00))
      else $error("malformed error item");

   // The datapath takes a transaction exactly when the handshake completes.
   a_accept: assert property (@(posedge clock) disable iff (reset)
      cmd.accept == (req_valid && req_ready))
      else $error("accept command out of step with handshake");
`endif

endmodule
